@@ rtl/core/rdi_pkg.sv @@
package rdi_pkg;

	localparam int CW      = 32;
	localparam int FB      = 16;
	localparam int EPS     = 1;
	localparam int PW      = 2 * CW - FB;
	localparam int SW      = PW + 3;
	localparam int DQW     = CW - 1;
	localparam int RW      = SW + FB;
	localparam int CMPW    = SW + DQW + 1;
	localparam int AW      = 5;

	localparam logic [2:0] REG_NX     = 3'd0;
	localparam logic [2:0] REG_NY     = 3'd1;
	localparam logic [2:0] REG_NZ     = 3'd2;
	localparam logic [2:0] REG_OFF    = 3'd3;
	localparam logic [2:0] REG_CX     = 3'd4;
	localparam logic [2:0] REG_CY     = 3'd5;
	localparam logic [2:0] REG_CZ     = 3'd6;
	localparam logic [2:0] REG_RADIUS = 3'd7;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] sum_t;

	typedef struct packed {
		coord_t nx;
		coord_t ny;
		coord_t nz;
		coord_t off;
		coord_t cx;
		coord_t cy;
		coord_t cz;
		logic [CW-2:0] rad;
	} disk_t;

	typedef struct packed {
		coord_t ex;
		coord_t ey;
		coord_t ez;
		coord_t dx;
		coord_t dy;
		coord_t dz;
	} ray_t;

	typedef struct packed {
		ray_t ray;
		logic facing;
	} side_t;

	// Exact product, then floored to the fixed-point fraction.
	function automatic prod_t mul_fx(input coord_t a, input coord_t b);
		logic signed [2*CW-1:0] p;
		p = a * b;
		return p[2*CW-1:FB];
	endfunction

endpackage

@@ rtl/core/rdi_dot.sv @@
module rdi_dot import rdi_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  disk_t          disk,
	input  logic           in_valid,
	output logic           in_ready,
	input  ray_t           ray_in,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [SW-1:0]  mag,
	output logic [SW-1:0]  dvs,
	output logic           neg,
	output side_t          side
);

	logic  v_s1, v_s2, rdy1, rdy2;
	prod_t pn_s1 [3];
	prod_t pd_s1 [3];
	ray_t  ray_s1;
	sum_t  den, num;

	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			pn_s1[0] <= mul_fx(disk.nx, ray_in.ex);
			pn_s1[1] <= mul_fx(disk.ny, ray_in.ey);
			pn_s1[2] <= mul_fx(disk.nz, ray_in.ez);
			pd_s1[0] <= mul_fx(disk.nx, ray_in.dx);
			pd_s1[1] <= mul_fx(disk.ny, ray_in.dy);
			pd_s1[2] <= mul_fx(disk.nz, ray_in.dz);
			ray_s1   <= ray_in;
		end
	end

	always_comb begin
		den = SW'(pd_s1[0]) + SW'(pd_s1[1]) + SW'(pd_s1[2]);
		num = SW'(pn_s1[0]) + SW'(pn_s1[1]) + SW'(pn_s1[2]) + SW'(disk.off);
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			mag         <= num[SW-1] ? SW'(-num) : SW'(num);
			dvs         <= den;
			neg         <= !num[SW-1] && (num != '0);
			side.ray    <= ray_s1;
			side.facing <= den > SW'(EPS);
		end
	end

	assign out_valid = v_s2;

endmodule

@@ rtl/core/rdi_div.sv @@
module rdi_div import rdi_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [SW-1:0]  mag,
	input  logic [SW-1:0]  dvs,
	input  logic           neg,
	input  side_t          side_in,
	output logic           out_valid,
	input  logic           out_ready,
	output coord_t         t,
	output side_t          side_out
);

	localparam int NS = DQW + 1;

	logic           vld   [NS+1];
	logic           rdy   [NS+2];
	logic [RW-1:0]  rem_s [NS];
	logic [SW-1:0]  d_s   [NS];
	logic [DQW-1:0] q_s   [NS];
	logic           neg_s [NS];
	logic           sat_s [NS];
	side_t          sd_s  [NS];

	assign rdy[NS+1] = out_ready;
	assign in_ready  = rdy[0];

	for (genvar j = 0; j <= NS; j++) begin : g_rdy
		assign rdy[j] = !vld[j] || rdy[j+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= NS; j++) vld[j] <= 1'b0;
		end else begin
			if (rdy[0]) vld[0] <= in_valid;
			for (int j = 1; j <= NS; j++) begin
				if (rdy[j]) vld[j] <= vld[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			rem_s[0] <= RW'(mag) << FB;
			d_s[0]   <= dvs;
			q_s[0]   <= '0;
			neg_s[0] <= neg;
			sat_s[0] <= CMPW'(mag) >= (CMPW'(dvs) << (DQW - FB));
			sd_s[0]  <= side_in;
		end
	end

	for (genvar j = 1; j < NS; j++) begin : g_bit
		localparam int K = DQW - j;
		logic [CMPW-1:0] sub;
		logic            take;
		assign sub  = CMPW'(d_s[j-1]) << K;
		assign take = CMPW'(rem_s[j-1]) >= sub;
		always_ff @(posedge clk) begin
			if (rdy[j] && vld[j-1]) begin
				rem_s[j] <= take ? rem_s[j-1] - RW'(sub) : rem_s[j-1];
				q_s[j]   <= q_s[j-1] | (DQW'(take) << K);
				d_s[j]   <= d_s[j-1];
				neg_s[j] <= neg_s[j-1];
				sat_s[j] <= sat_s[j-1];
				sd_s[j]  <= sd_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NS] && vld[NS-1]) begin
			if (sat_s[NS-1]) begin
				t <= neg_s[NS-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
			end else begin
				t <= neg_s[NS-1] ? -coord_t'({1'b0, q_s[NS-1]}) : coord_t'({1'b0, q_s[NS-1]});
			end
			side_out <= sd_s[NS-1];
		end
	end

	assign out_valid = vld[NS];

endmodule

@@ rtl/core/rdi_hit.sv @@
module rdi_hit import rdi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  disk_t   disk,
	input  logic    in_valid,
	output logic    in_ready,
	input  coord_t  t,
	input  side_t   side,
	output logic    out_valid,
	input  logic    out_ready,
	output logic    hit,
	output coord_t  t_near
);

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              rdy1, rdy2, rdy3, rdy4;
	prod_t             pv_s1 [3];
	coord_t            e_s1  [3];
	coord_t            t_s1, t_s2, t_s3;
	logic              f_s1, inr_s2, inr_s3;
	logic [CW-2:0]     dl_s2 [3];
	logic [2*CW-3:0]   sq_s3 [3];
	logic [2*CW-3:0]   rr_s3;
	sum_t              df    [3];
	logic [SW-1:0]     ad    [3];
	coord_t            cc    [3];
	logic [2*CW-1:0]   total;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			pv_s1[0] <= mul_fx(t, side.ray.dx);
			pv_s1[1] <= mul_fx(t, side.ray.dy);
			pv_s1[2] <= mul_fx(t, side.ray.dz);
			e_s1[0]  <= side.ray.ex;
			e_s1[1]  <= side.ray.ey;
			e_s1[2]  <= side.ray.ez;
			t_s1     <= t;
			f_s1     <= side.facing;
		end
	end

	assign cc[0] = disk.cx;
	assign cc[1] = disk.cy;
	assign cc[2] = disk.cz;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			df[i] = SW'(e_s1[i]) + SW'(pv_s1[i]) - SW'(cc[i]);
			ad[i] = df[i][SW-1] ? SW'(-df[i]) : SW'(df[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			inr_s2 <= f_s1 && (ad[0] <= SW'(disk.rad)) && (ad[1] <= SW'(disk.rad))
				&& (ad[2] <= SW'(disk.rad));
			for (int i = 0; i < 3; i++) dl_s2[i] <= ad[i][CW-2:0];
			t_s2 <= t_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			for (int i = 0; i < 3; i++) sq_s3[i] <= dl_s2[i] * dl_s2[i];
			rr_s3  <= disk.rad * disk.rad;
			inr_s3 <= inr_s2;
			t_s3   <= t_s2;
		end
	end

	assign total = (2*CW)'(sq_s3[0]) + (2*CW)'(sq_s3[1]) + (2*CW)'(sq_s3[2]);

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			hit    <= inr_s3 && (total <= (2*CW)'(rr_s3));
			t_near <= (inr_s3 && (total <= (2*CW)'(rr_s3))) ? t_s3 : '0;
		end
	end

	assign out_valid = v_s4;

endmodule

@@ rtl/core/ray_disk_intersect_core.sv @@
// Channel  Direction  Handshake            Payload
// ray      in         in_valid/in_ready    eye_x..eye_z, dir_x..dir_z
// result   out        out_valid/out_ready  hit, t_near
// config   in         APB write/read       eight disk registers, 4-byte stride
//
// One ray per clock is taken, unless the pipeline is stalled by a blocked result channel.
// The divider forms one quotient bit per stage.
// Reset clears every valid bit and sets all disk registers to zero.
// Each stage stalls only while it is full and the stage after it is blocked.
module ray_disk_intersect_core import rdi_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          in_valid,
	output logic          in_ready,
	input  coord_t        eye_x,
	input  coord_t        eye_y,
	input  coord_t        eye_z,
	input  coord_t        dir_x,
	input  coord_t        dir_y,
	input  coord_t        dir_z,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          hit,
	output coord_t        t_near
);

	disk_t         disk_q;
	logic [2:0]    idx;
	ray_t          ray;
	logic          dv, dr, qv, qr;
	logic [SW-1:0] mag, dvs;
	logic          neg;
	side_t         side_d, side_q;
	coord_t        t;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_NX:     disk_q.nx  <= pwdata;
				REG_NY:     disk_q.ny  <= pwdata;
				REG_NZ:     disk_q.nz  <= pwdata;
				REG_OFF:    disk_q.off <= pwdata;
				REG_CX:     disk_q.cx  <= pwdata;
				REG_CY:     disk_q.cy  <= pwdata;
				REG_CZ:     disk_q.cz  <= pwdata;
				REG_RADIUS: disk_q.rad <= pwdata[CW-2:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_NX:     prdata = disk_q.nx;
			REG_NY:     prdata = disk_q.ny;
			REG_NZ:     prdata = disk_q.nz;
			REG_OFF:    prdata = disk_q.off;
			REG_CX:     prdata = disk_q.cx;
			REG_CY:     prdata = disk_q.cy;
			REG_CZ:     prdata = disk_q.cz;
			REG_RADIUS: prdata = {1'b0, disk_q.rad};
			default:    prdata = '0;
		endcase
	end

	assign ray = '{ex: eye_x, ey: eye_y, ez: eye_z, dx: dir_x, dy: dir_y, dz: dir_z};

	rdi_dot u_dot (
		.clk, .arst_n, .disk(disk_q), .in_valid, .in_ready, .ray_in(ray),
		.out_valid(dv), .out_ready(dr), .mag, .dvs, .neg, .side(side_d)
	);

	rdi_div u_div (
		.clk, .arst_n, .in_valid(dv), .in_ready(dr), .mag, .dvs, .neg,
		.side_in(side_d), .out_valid(qv), .out_ready(qr), .t, .side_out(side_q)
	);

	rdi_hit u_hit (
		.clk, .arst_n, .disk(disk_q), .in_valid(qv), .in_ready(qr), .t,
		.side(side_q), .out_valid, .out_ready, .hit, .t_near
	);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> t_near == '0)
		else $error("A missed beat carries a non-zero t_near.");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("Input is blocked although the pipeline can move.");

	a_radius_wr: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && idx == REG_RADIUS |=>
			disk_q.rad == $past(pwdata[CW-2:0]))
		else $error("Radius register did not take the written value.");

endmodule
